FILE: hdl/dsfe_pkg.sv
// Shared types and constants for the DLE byte-stuffing frame encoder.
// Holds the job word format passed from the front end to the back end.
// No dependencies.
package dsfe_pkg;

    localparam int BYTE_W  = 8;
    localparam int HLEN_W  = 4;
    localparam int SUM_W   = 7;
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    localparam logic [BYTE_W-1:0] ESC_BYTE   = 8'h10;
    localparam logic [BYTE_W-1:0] CHECK_MARK = 8'h80;
    localparam logic [BYTE_W-1:0] STX_BYTE   = 8'h02;
    localparam logic [BYTE_W-1:0] ETX_BYTE   = 8'h03;
    localparam logic [BYTE_W-1:0] EOT_BYTE   = 8'h04;
    localparam logic [BYTE_W-1:0] ENQ_BYTE   = 8'h05;

    localparam logic [HLEN_W-1:0] HLEN_RESET = 4'd3;

    typedef enum logic [1:0] {
        JOB_PLAIN,
        JOB_STUFF,
        JOB_END
    } job_kind_t;

    typedef struct packed {
        job_kind_t          kind;
        logic [BYTE_W-1:0]  data;
        logic [SUM_W-1:0]   chk;
    } job_t;

    function automatic logic needs_escape(input logic [BYTE_W-1:0] b);
        logic hit;
        unique case (b) inside
            STX_BYTE, ETX_BYTE, EOT_BYTE, ENQ_BYTE, ESC_BYTE: hit = 1'b1;
            default:                                          hit = 1'b0;
        endcase
        return hit;
    endfunction

endpackage

FILE: hdl/dsfe_in_if.sv
// Input channel of the frame encoder: one raw frame byte per word.
// Depends on dsfe_pkg.
interface dsfe_in_if
    import dsfe_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] frame_byte;
    logic              is_end_byte;

    modport source (output valid, frame_byte, is_end_byte, input ready);
    modport sink   (input valid, frame_byte, is_end_byte, output ready);
endinterface

FILE: hdl/dsfe_out_if.sv
// Output channel of the frame encoder: one line byte per word.
// Depends on dsfe_pkg.
interface dsfe_out_if
    import dsfe_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] line_byte;
    logic              frame_done;
    logic              last_of_run;

    modport source (output valid, line_byte, frame_done, last_of_run, input ready);
    modport sink   (input valid, line_byte, frame_done, last_of_run, output ready);
endinterface

FILE: hdl/dle_stuffed_frame_encoder_core.sv
// Top level of the DLE byte-stuffing frame encoder.
// Depends on dsfe_pkg, dsfe_in_if, dsfe_out_if, dsfe_front, dsfe_job_queue, dsfe_back.
//
// Takes one raw frame byte per input word and sends line bytes out one per
// word: header bytes and plain body bytes give one word, a body byte of
// 0x02..0x05 or 0x10 gives an escape 0x10 then the byte, and the end byte
// gives itself then the checksum (low seven bits of the body byte sum, with
// bit 7 set, frame_done high). The output port moves one word per cycle
// while out_ch.ready is high; a two-entry job queue lets the input keep
// accepting while the output stalls, until the queue is full.
// header_length (reset 3) is written through cfg_wr_en/cfg_wr_data.
module dle_stuffed_frame_encoder_core
    import dsfe_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [HLEN_W-1:0] cfg_wr_data,
    dsfe_in_if.sink           in_ch,
    dsfe_out_if.source        out_ch
);

    logic q_full;
    logic q_push;
    job_t q_job;
    logic q_pop;
    logic head_valid;
    job_t head_job;

    dsfe_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_ch       (in_ch),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_job       (q_job)
    );

    dsfe_job_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_job   (q_job),
        .pop        (q_pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    dsfe_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (q_pop),
        .out_ch     (out_ch)
    );

endmodule

FILE: hdl/dsfe_front.sv
// Front end: accepts frame bytes, tracks header position and checksum,
// and turns each byte into a job word. Depends on dsfe_pkg, dsfe_in_if.
module dsfe_front
    import dsfe_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [HLEN_W-1:0] cfg_wr_data,
    dsfe_in_if.sink           in_ch,
    input  logic              q_full,
    output logic              q_push,
    output job_t              q_job
);

    logic [HLEN_W-1:0] header_length_reg;
    logic [HLEN_W-1:0] byte_position_reg, byte_position_next;
    logic [SUM_W-1:0]  running_sum_reg, running_sum_next;
    logic              in_header;
    logic [SUM_W-1:0]  sum_added;

    assign in_ch.ready = !q_full;
    assign q_push      = in_ch.valid && in_ch.ready;
    assign in_header   = byte_position_reg < header_length_reg;
    assign sum_added   = running_sum_reg + in_ch.frame_byte[SUM_W-1:0];

    always_comb
    begin
        q_job.data = in_ch.frame_byte;
        q_job.chk  = in_header ? running_sum_reg : sum_added;
        if (in_ch.is_end_byte)
        begin
            q_job.kind = JOB_END;
        end
        else if (!in_header && needs_escape(in_ch.frame_byte))
        begin
            q_job.kind = JOB_STUFF;
        end
        else
        begin
            q_job.kind = JOB_PLAIN;
        end

        if (in_ch.is_end_byte)
        begin
            byte_position_next = '0;
            running_sum_next   = '0;
        end
        else
        begin
            byte_position_next = in_header ? byte_position_reg + 1'b1 : header_length_reg;
            running_sum_next   = q_job.chk;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_length_reg <= HLEN_RESET;
            byte_position_reg <= '0;
            running_sum_reg   <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                header_length_reg <= cfg_wr_data;
            end
            if (q_push)
            begin
                byte_position_reg <= byte_position_next;
                running_sum_reg   <= running_sum_next;
            end
        end
    end

endmodule

FILE: hdl/dsfe_job_queue.sv
// Short FIFO of job words between the front end and the back end.
// Depends on dsfe_pkg.
module dsfe_job_queue
    import dsfe_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output logic full,
    output logic head_valid,
    output job_t head_job
);

    job_t              entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full       = count_reg == QCNT_W'(QDEPTH);
    assign head_valid = count_reg != '0;
    assign head_job   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == QCNT_W'(QDEPTH) && push |-> pop)
        else $error("job queue overflow");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("job queue underflow");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("job queue count did not advance");
`endif

endmodule

FILE: hdl/dsfe_back.sv
// Back end: expands job words into line bytes (escape, data, checksum)
// through an output register. Depends on dsfe_pkg, dsfe_out_if.
module dsfe_back
    import dsfe_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      head_valid,
    input  job_t      head_job,
    output logic      pop,
    dsfe_out_if.source out_ch
);

    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] line_byte_reg, line_byte_next;
    logic              frame_done_reg, frame_done_next;
    logic              last_reg, last_next;
    logic              phase_reg, phase_next;
    logic              slot_free;

    assign slot_free          = !out_valid_reg || out_ch.ready;
    assign out_ch.valid       = out_valid_reg;
    assign out_ch.line_byte   = line_byte_reg;
    assign out_ch.frame_done  = frame_done_reg;
    assign out_ch.last_of_run = last_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg && !out_ch.ready;
        line_byte_next  = line_byte_reg;
        frame_done_next = frame_done_reg;
        last_next       = last_reg;
        phase_next      = phase_reg;
        pop             = 1'b0;
        if (slot_free && head_valid)
        begin
            out_valid_next  = 1'b1;
            frame_done_next = 1'b0;
            unique case (head_job.kind)
                JOB_PLAIN:
                begin
                    line_byte_next = head_job.data;
                    last_next      = 1'b1;
                    pop            = 1'b1;
                end
                JOB_STUFF:
                begin
                    line_byte_next = phase_reg ? head_job.data : ESC_BYTE;
                    last_next      = phase_reg;
                    pop            = phase_reg;
                    phase_next     = !phase_reg;
                end
                JOB_END:
                begin
                    line_byte_next  = phase_reg ? (CHECK_MARK | BYTE_W'(head_job.chk))
                                                : head_job.data;
                    frame_done_next = phase_reg;
                    last_next       = phase_reg;
                    pop             = phase_reg;
                    phase_next      = !phase_reg;
                end
                default:
                begin
                    line_byte_next = head_job.data;
                    last_next      = 1'b1;
                    pop            = 1'b1;
                    phase_next     = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        line_byte_reg  <= line_byte_next;
        frame_done_reg <= frame_done_next;
        last_reg       <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            phase_reg     <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
        end
    end

`ifndef SYNTHESIS
    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && frame_done_reg |-> last_reg)
        else $error("frame end word not marked last");
    a_phase_holds_job: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> head_valid && head_job.kind != JOB_PLAIN)
        else $error("second half pending without a two-word job");
    a_half_then_rest: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !last_reg |-> phase_reg)
        else $error("first half shown but no second half pending");
`endif

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// Testbench for dle_stuffed_frame_encoder_core: directed frames, then random frames
// under several header lengths, each line word checked against a local encoder model.
// Depends on dsfe_pkg, dsfe_in_if, dsfe_out_if and the encoder RTL.
module tb_top;
    import dsfe_pkg::*;

    localparam int CLK_HALF    = 2;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_WORDS = 680;

    typedef struct packed {
        logic [BYTE_W-1:0] line_byte;
        logic              frame_done;
        logic              last_of_run;
    } line_word_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_wr_en;
    logic [HLEN_W-1:0] cfg_wr_data;

    dsfe_in_if  in_ch ();
    dsfe_out_if out_ch ();

    dle_stuffed_frame_encoder_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_ch       (in_ch),
        .out_ch      (out_ch)
    );

    line_word_t        line_words_due[$];
    logic [HLEN_W-1:0] hdr_len   = HLEN_RESET;
    logic [HLEN_W-1:0] frame_pos = '0;
    logic [SUM_W-1:0]  body_sum  = '0;
    int                mismatches  = 0;
    int                cycle_count = 0;
    int                stall_left  = 0;
    int                words_sent  = 0;
    bit                quiet       = 1'b0;

    always #(CLK_HALF) clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    function automatic logic is_ctrl_byte(input logic [BYTE_W-1:0] b);
        return b == STX_BYTE || b == ETX_BYTE || b == EOT_BYTE || b == ENQ_BYTE
            || b == ESC_BYTE;
    endfunction

    function automatic logic [BYTE_W-1:0] pick_byte();
        if ($urandom_range(0, 9) < 3)
            case ($urandom_range(0, 4))
                0:       return STX_BYTE;
                1:       return ETX_BYTE;
                2:       return EOT_BYTE;
                3:       return ENQ_BYTE;
                default: return ESC_BYTE;
            endcase
        return BYTE_W'($urandom_range(0, 255));
    endfunction

    task automatic encode_byte(input logic [BYTE_W-1:0] b, input logic is_end);
        logic in_hdr;
        in_hdr = frame_pos < hdr_len;
        if (in_hdr)
            frame_pos = frame_pos + 1'b1;
        else
            frame_pos = hdr_len;
        if (!in_hdr)
            body_sum = body_sum + b[SUM_W-1:0];
        if (is_end)
        begin
            line_words_due.push_back('{b, 1'b0, 1'b0});
            line_words_due.push_back('{CHECK_MARK | BYTE_W'(body_sum), 1'b1, 1'b1});
            frame_pos = '0;
            body_sum  = '0;
        end
        else if (!in_hdr && is_ctrl_byte(b))
        begin
            line_words_due.push_back('{ESC_BYTE, 1'b0, 1'b0});
            line_words_due.push_back('{b, 1'b0, 1'b1});
        end
        else
            line_words_due.push_back('{b, 1'b0, 1'b1});
    endtask

    // predict on accepted input words, then check accepted output words
    always @(posedge clk)
    begin
        line_word_t due;
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
                encode_byte(in_ch.frame_byte, in_ch.is_end_byte);
            if (cfg_wr_en)
                hdr_len = cfg_wr_data;
            if (out_ch.valid && out_ch.ready)
            begin
                if (line_words_due.size() == 0)
                begin
                    $error("unexpected line word: line_byte %h frame_done %b last_of_run %b",
                           out_ch.line_byte, out_ch.frame_done, out_ch.last_of_run);
                    mismatches++;
                end
                else
                begin
                    due = line_words_due.pop_front();
                    if (out_ch.line_byte !== due.line_byte)
                    begin
                        $error("line_byte: expected %h, actual %h",
                               due.line_byte, out_ch.line_byte);
                        mismatches++;
                    end
                    if (out_ch.frame_done !== due.frame_done)
                    begin
                        $error("frame_done: expected %b, actual %b",
                               due.frame_done, out_ch.frame_done);
                        mismatches++;
                    end
                    if (out_ch.last_of_run !== due.last_of_run)
                    begin
                        $error("last_of_run: expected %b, actual %b",
                               due.last_of_run, out_ch.last_of_run);
                        mismatches++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            out_ch.ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            out_ch.ready <= 1'b1;
            stall_left = pick_gap();
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("dle_stuffed_frame_encoder_core regression: fail");
            $finish;
        end
    end

    task automatic send_word(input logic [BYTE_W-1:0] b, input logic is_end);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.frame_byte  <= b;
        in_ch.is_end_byte <= is_end;
        do
            @(posedge clk);
        while (!in_ch.ready);
        words_sent++;
    endtask

    task automatic wait_drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (line_words_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_hdr_len(input logic [HLEN_W-1:0] len);
        wait_drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= len;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic test_default_header();
        send_word(ESC_BYTE, 1'b0);
        send_word(STX_BYTE, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(ETX_BYTE, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(ESC_BYTE, 1'b1);
    endtask

    task automatic test_end_in_header();
        send_word(ENQ_BYTE, 1'b0);
        send_word(EOT_BYTE, 1'b1);
    endtask

    task automatic test_zero_header();
        write_hdr_len('0);
        send_word(STX_BYTE, 1'b0);
        send_word(ESC_BYTE, 1'b0);
        send_word(8'h80, 1'b0);
        send_word(8'h7F, 1'b1);
    endtask

    task automatic test_full_header();
        write_hdr_len('1);
        send_word(ESC_BYTE, 1'b0);
        send_word(STX_BYTE, 1'b0);
        send_word(8'hFF, 1'b1);
    endtask

    task automatic test_header_change_mid_frame();
        write_hdr_len(4'd3);
        send_word(8'h31, 1'b0);
        send_word(8'h32, 1'b0);
        // lower below the current position: the next byte is body
        write_hdr_len(4'd1);
        send_word(EOT_BYTE, 1'b0);
        send_word(8'hAA, 1'b1);
    endtask

    task automatic test_random_frames();
        logic [HLEN_W-1:0] phase_len[8];
        int phase_target;
        int frame_len;
        int switch_at;
        phase_len = '{4'd0, 4'd15, 4'd3, 4'd9, 4'd1, HLEN_W'($urandom_range(0, 15)),
                      4'd15, 4'd0};
        for (int p = 0; p < 8; p++)
        begin
            write_hdr_len(phase_len[p]);
            quiet = (p == 2);
            phase_target = words_sent + RANDOM_WORDS / 8;
            while (words_sent < phase_target)
            begin
                if ($urandom_range(0, 4) == 0)
                    frame_len = $urandom_range(13, 40);
                else
                    frame_len = $urandom_range(1, 12);
                switch_at = -1;
                if (frame_len > 1 && $urandom_range(0, 7) == 0)
                    switch_at = $urandom_range(1, frame_len - 1);
                for (int k = 0; k < frame_len; k++)
                begin
                    if (k == switch_at)
                        write_hdr_len(HLEN_W'($urandom_range(0, 15)));
                    send_word(pick_byte(), k == frame_len - 1);
                end
            end
        end
        quiet = 1'b0;
    endtask

    initial
    begin
        rst_n             = 1'b0;
        cfg_wr_en         = 1'b0;
        cfg_wr_data       = '0;
        in_ch.valid       = 1'b0;
        in_ch.frame_byte  = '0;
        in_ch.is_end_byte = 1'b0;
        out_ch.ready      = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_header();
        test_end_in_header();
        test_zero_header();
        test_full_header();
        test_header_change_mid_frame();
        test_random_frames();

        wait_drain();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && line_words_due.size() == 0)
            $display("dle_stuffed_frame_encoder_core regression: pass");
        else
            $display("dle_stuffed_frame_encoder_core regression: fail");
        $finish;
    end

endmodule

FILE: dle_stuffed_frame_encoder_core.f
hdl/dsfe_pkg.sv
hdl/dsfe_in_if.sv
hdl/dsfe_out_if.sv
hdl/dsfe_front.sv
hdl/dsfe_job_queue.sv
hdl/dsfe_back.sv
hdl/dle_stuffed_frame_encoder_core.sv
tb/tb_top.sv
